### sv/sha1s_pkg.sv
package sha1s_pkg;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [31:0] K_STG0 = 32'h5A827999;
    localparam logic [31:0] K_STG1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_STG2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_STG3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned LEN_START  = 56;
    localparam int unsigned BLOCK_LAST = 63;

    typedef enum logic [1:0] {
        STG_CH   = 2'd0,
        STG_PAR0 = 2'd1,
        STG_MAJ  = 2'd2,
        STG_PAR1 = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_MARK = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      load_work;
        logic      round_en;
        stage_t    stage;
        logic      add_chain;
        logic      emit;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       out_free;
    } sts_t;

endpackage

### sv/sha1s_ifs.sv
interface sha1s_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface sha1s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    modport source (
        output valid,
        output digest_word0,
        output digest_word1,
        output digest_word2,
        output digest_word3,
        output digest_word4,
        input  ready
    );
    modport sink (
        input  valid,
        input  digest_word0,
        input  digest_word1,
        input  digest_word2,
        input  digest_word3,
        input  digest_word4,
        output ready
    );
endinterface

### sv/sha1s_ctrl.sv
module sha1s_ctrl
    import sha1s_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_action,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_RND  = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] rnd_reg, rnd_next;
    logic       fin_reg, fin_next;
    logic       len_ok_reg, len_ok_next;
    logic       blk_end;

    assign blk_end = (sts.fill == 6'(BLOCK_LAST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rnd_reg    <= '0;
            fin_reg    <= 1'b0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rnd_reg    <= rnd_next;
            fin_reg    <= fin_next;
            len_ok_reg <= len_ok_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        fin_next    = fin_reg;
        len_ok_next = len_ok_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.byte_sel = SEL_DATA;
        cmd.stage    = STG_CH;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift_en = 1'b1;
                    if (in_action == ACT_FINISH)
                    begin
                        cmd.byte_sel = SEL_MARK;
                        fin_next     = 1'b1;
                        len_ok_next  = (sts.fill < 6'(LEN_START));
                    end
                    if (blk_end)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = ST_RND;
                    end
                    else if (in_action == ACT_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                if (len_ok_reg && (sts.fill >= 6'(LEN_START)))
                    cmd.byte_sel = SEL_LEN;
                else
                    cmd.byte_sel = SEL_ZERO;
                if (blk_end)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_RND;
                end
            end

            ST_RND:
            begin
                cmd.round_en = 1'b1;
                priority if (rnd_reg < 7'd20)
                    cmd.stage = STG_CH;
                else if (rnd_reg < 7'd40)
                    cmd.stage = STG_PAR0;
                else if (rnd_reg < 7'd60)
                    cmd.stage = STG_MAJ;
                else
                    cmd.stage = STG_PAR1;
                if (rnd_reg == 7'(ROUNDS - 1))
                begin
                    rnd_next   = '0;
                    state_next = ST_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end

            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_ok_reg)
                    state_next = ST_FIN;
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end

            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    fin_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sha1s_datapath.sv
module sha1s_datapath
    import sha1s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  cmd_t       cmd,
    output sts_t       sts,
    sha1s_out_if.source digest
);

    logic [511:0]       blk_reg, blk_next;
    logic [4:0][31:0]   chain_reg, chain_next;
    logic [31:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]         fill_reg, fill_next;
    logic [60:0]        cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [4:0][31:0]   out_reg;

    logic [7:0][7:0]    len_bytes;
    logic [7:0]         shift_byte;
    logic [31:0]        w_cur, w_new_raw, w_new, f_val, k_val, t_val;

    // message length in bits, big-endian byte order
    assign len_bytes = {cnt_reg, 3'b000};

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_DATA: shift_byte = data_byte;
            SEL_MARK: shift_byte = PAD_MARK;
            SEL_ZERO: shift_byte = 8'h00;
            SEL_LEN:  shift_byte = len_bytes[3'd7 - fill_reg[2:0]];
            default:  shift_byte = 8'h00;
        endcase
    end

    // oldest schedule word sits at the top of the block register
    assign w_cur = blk_reg[511:480];
    assign w_new_raw = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
    assign w_new = {w_new_raw[30:0], w_new_raw[31]};

    always_comb
    begin
        unique case (cmd.stage)
            STG_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K_STG0;
            end
            STG_PAR0:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_STG1;
            end
            STG_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K_STG2;
            end
            STG_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_STG3;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_STG3;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
            blk_next = {blk_reg[503:0], shift_byte};
        else if (cmd.round_en)
            blk_next = {blk_reg[479:0], w_new};
    end

    always_comb
    begin
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && digest.ready)
            out_valid_next = 1'b0;
        if (cmd.shift_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (cmd.byte_sel == SEL_DATA)
                cnt_next = cnt_reg + 61'd1;
        end
        if (cmd.add_chain)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            fill_next      = '0;
            cnt_next       = '0;
            chain_next     = {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.emit)
            out_reg <= chain_reg;
    end

    assign sts.fill     = fill_reg;
    assign sts.out_free = !out_valid_reg || digest.ready;

    assign digest.valid        = out_valid_reg;
    assign digest.digest_word0 = out_reg[0];
    assign digest.digest_word1 = out_reg[1];
    assign digest.digest_word2 = out_reg[2];
    assign digest.digest_word3 = out_reg[3];
    assign digest.digest_word4 = out_reg[4];

endmodule

### sv/sha1_stream_hash.sv
// channel  | dir | payload                        | notes
// msg      | in  | action, data_byte              | absorb one byte or finish
// digest   | out | digest_word0 .. digest_word4   | one request per finish
//
// an absorb request is accepted in the idle state; the 64th byte of a block
// starts 80 rounds on the single round unit, then the chaining add
// a finish adds the 0x80 mark, zero padding and the bit length, with a second
// padded block when the length spills over, then loads the digest register
// msg is refused while a block is being padded or compressed
// the digest register holds its request until taken; new bytes are accepted
// meanwhile, and a later finish waits for the register to drain
// rst_n is asynchronous and returns the initial chaining value and counts
module sha1_stream_hash
    import sha1s_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha1s_in_if.sink    msg,
    sha1s_out_if.source digest
);

    cmd_t cmd;
    sts_t sts;

    sha1s_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_action (msg.action),
        .in_ready  (msg.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sha1s_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg.data_byte),
        .cmd       (cmd),
        .sts       (sts),
        .digest    (digest)
    );

endmodule

### sv/sha1s_checker.sv
module sha1s_checker
    import sha1s_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [159:0] out_data
);

    // digest request holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("digest request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("digest changed while stalled");

    // a finish always leads to padding and compression
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_action == ACT_FINISH)) |=> !in_ready)
        else $error("input accepted right after finish");

    // a new digest never appears right after an accepted request
    a_digest_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("digest issued directly after an input request");

endmodule

bind sha1_stream_hash sha1s_checker u_sha1s_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .in_action (msg.action),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_data  ({digest.digest_word0, digest.digest_word1, digest.digest_word2,
                 digest.digest_word3, digest.digest_word4})
);
